// ----- design/lcbm_pkg.sv -----
// Shared constants, codes and types of the legend color band matcher.
package lcbm_pkg;

   // Defaults for the top-level parameters.
   localparam int STORE_DEPTH_DEFAULT = 1024;
   localparam int MAX_LEGEND_DEFAULT  = 16;

   // Fixed field widths.
   localparam int BOUND_W     = 11;
   localparam int LEGEND_W    = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int CHANNEL_W   = 8;
   localparam int COLOR_W     = 3 * CHANNEL_W;
   localparam int BAND_W      = 4;
   localparam int DIST_W      = 8;
   localparam int SUM_W       = 10;

   // Queue depths between the parts of the block.
   localparam int OP_QUEUE_DEPTH  = 4;
   localparam int RSP_QUEUE_DEPTH = 2;

   // Matching constants.
   localparam int                LEGEND_MIN    = 2;
   localparam int                MATCH_LIMIT   = 768;
   localparam logic [DIST_W-1:0] NO_MATCH_DIST = 8'd255;

   // Input commands.
   typedef enum logic [1:0] {
      CMD_BEGIN  = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_END    = 2'd2
   } command_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOWER  = 2'd0,
      CSR_UPPER  = 2'd1,
      CSR_LEGEND = 2'd2
   } csr_index_type;

   // Kinds of operation passed from the front to the back.
   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_MATCH = 1'b1
   } op_kind_type;

   // Back-end sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_ORDER,
      ST_DIVIDE,
      ST_PREP,
      ST_SCAN,
      ST_RESULT
   } back_state_type;

   // One result transaction.
   typedef struct packed {
      logic [BAND_W-1:0] band_index;
      logic              matched;
      logic [DIST_W-1:0] distance;
   } result_type;

endpackage

// ----- design/lcbm_fifo.sv -----
// Small register-based first-in first-out queue.
module lcbm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign full  = (fill_ff == NW'(DEPTH));
   assign empty = (fill_ff == '0);
   assign rdata = entry_ff[rd_ptr_ff];

   // Pointer and fill-level update.
   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- design/lcbm_front.sv -----
// Front end: accepts input transactions, tracks capture state and issues operations.
module lcbm_front
   import lcbm_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT,
   localparam int CW  = $clog2(STORE_DEPTH + 1),
   localparam int OPW = 1 + CW + COLOR_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic [1:0]           req_command,
   input  logic [CHANNEL_W-1:0] req_red,
   input  logic [CHANNEL_W-1:0] req_green,
   input  logic [CHANNEL_W-1:0] req_blue,
   input  logic                 op_full,
   output logic                 op_push,
   output logic [OPW-1:0]       op_data
);

   logic          capture_ff, capture_in;
   logic [CW-1:0] count_ff, count_in;
   logic          accept;
   op_kind_type   op_kind;

   // Classify the accepted transaction into a store write, a match or nothing.
   always_comb begin
      accept     = req_push && !op_full;
      capture_in = capture_ff;
      count_in   = count_ff;
      op_push    = 1'b0;
      op_kind    = OP_WRITE;
      if (accept) begin
         unique case (req_command)
            CMD_BEGIN: begin
               count_in   = '0;
               capture_in = 1'b1;
            end
            CMD_SAMPLE: begin
               if (capture_ff) begin
                  // A sample that finds the store full is dropped.
                  if (count_ff < CW'(STORE_DEPTH)) begin
                     op_push  = 1'b1;
                     op_kind  = OP_WRITE;
                     count_in = count_ff + CW'(1);
                  end
               end else if (count_ff != '0) begin
                  op_push = 1'b1;
                  op_kind = OP_MATCH;
               end
            end
            CMD_END: begin
               capture_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
      // The count field is the write address or the store size seen by a match.
      op_data = {op_kind, count_ff, req_red, req_green, req_blue};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capture_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         capture_ff <= capture_in;
         count_ff   <= count_in;
      end
   end

endmodule

// ----- design/lcbm_back.sv -----
// Back end: owns the color store, performs writes and the band search for matches.
module lcbm_back
   import lcbm_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT,
   parameter int MAX_LEGEND  = MAX_LEGEND_DEFAULT,
   localparam int CW  = $clog2(STORE_DEPTH + 1),
   localparam int OPW = 1 + CW + COLOR_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                op_empty,
   input  logic [OPW-1:0]      op_data,
   output logic                op_pop,
   input  logic [BOUND_W-1:0]  lower_bound,
   input  logic [BOUND_W-1:0]  upper_bound,
   input  logic [LEGEND_W-1:0] legend_count,
   input  logic                res_full,
   output logic                res_push,
   output result_type          res_data
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int BW = $clog2(MAX_LEGEND);
   localparam int XW = (CW > BOUND_W) ? CW : BOUND_W;
   localparam int SW = $clog2(CW);
   localparam int PW = DIST_W + BW;

   // Color store.
   logic [COLOR_W-1:0] store_mem [STORE_DEPTH];
   logic [COLOR_W-1:0] rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;

   // Unpacked operation.
   op_kind_type        op_kind;
   logic [CW-1:0]      op_count;
   logic [COLOR_W-1:0] op_rgb;

   // Control registers.
   back_state_type state_ff, state_in;
   logic [SW-1:0]  step_ff, step_in;
   logic [BW-1:0]  issue_ff, issue_in;
   logic           rd_valid_ff, rd_valid_in;
   logic           dist_valid_ff, dist_valid_in;

   // Datapath registers.
   logic [COLOR_W-1:0] rgb_ff, rgb_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      lo_ff, lo_in;
   logic [CW-1:0]      hi_ff, hi_in;
   logic [BW-1:0]      bands_ff, bands_in;
   logic [CW-1:0]      quot_ff, quot_in;
   logic [BW-1:0]      rem_ff, rem_in;
   logic [CW-1:0]      chunk_ff, chunk_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [BW-1:0]      rd_idx_ff, rd_idx_in;
   logic [SUM_W-1:0]   dist_ff, dist_in;
   logic [BW-1:0]      dist_idx_ff, dist_idx_in;
   logic [DIST_W-1:0]  best_ff, best_in;
   logic [BW-1:0]      best_idx_ff, best_idx_in;

   // Combinational helpers.
   logic [XW-1:0]        cnt_x;
   logic [BW:0]          rem_shift;
   logic [BW:0]          rem_diff;
   logic                 issue_more;
   logic [CHANNEL_W-1:0] diff_r, diff_g, diff_b;
   logic [CHANNEL_W-1:0] store_r, store_g, store_b;
   logic [PW-1:0]        product;

   assign op_kind  = op_kind_type'(op_data[OPW-1]);
   assign op_count = op_data[COLOR_W +: CW];
   assign op_rgb   = op_data[COLOR_W-1:0];

   assign store_r = rd_data_ff[2*CHANNEL_W +: CHANNEL_W];
   assign store_g = rd_data_ff[CHANNEL_W +: CHANNEL_W];
   assign store_b = rd_data_ff[0 +: CHANNEL_W];

   // Per-channel absolute differences between the pixel and the stored color.
   always_comb begin
      diff_r = (rgb_ff[2*CHANNEL_W +: CHANNEL_W] > store_r) ?
               rgb_ff[2*CHANNEL_W +: CHANNEL_W] - store_r :
               store_r - rgb_ff[2*CHANNEL_W +: CHANNEL_W];
      diff_g = (rgb_ff[CHANNEL_W +: CHANNEL_W] > store_g) ?
               rgb_ff[CHANNEL_W +: CHANNEL_W] - store_g :
               store_g - rgb_ff[CHANNEL_W +: CHANNEL_W];
      diff_b = (rgb_ff[0 +: CHANNEL_W] > store_b) ?
               rgb_ff[0 +: CHANNEL_W] - store_b :
               store_b - rgb_ff[0 +: CHANNEL_W];
   end

   // Sequencer: next state, datapath next values and handshake outputs.
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      issue_in      = issue_ff;
      rd_valid_in   = 1'b0;
      dist_valid_in = rd_valid_ff;
      rgb_in        = rgb_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      bands_in      = bands_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      chunk_in      = chunk_ff;
      pos_in        = pos_ff;
      rd_idx_in     = issue_ff;
      dist_in       = SUM_W'(diff_r) + SUM_W'(diff_g) + SUM_W'(diff_b);
      dist_idx_in   = rd_idx_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      op_pop        = 1'b0;
      wr_en         = 1'b0;
      res_push      = 1'b0;
      cnt_x         = XW'(count_ff);
      rem_shift     = {rem_ff, quot_ff[CW-1]};
      rem_diff      = rem_shift - {1'b0, bands_ff};
      issue_more    = (issue_ff != bands_ff);
      product       = PW'(best_ff) * PW'(bands_ff);

      // Centers past the stored data read the last stored entry.
      if (pos_ff >= count_ff) begin
         rd_addr = AW'(count_ff - CW'(1));
      end else begin
         rd_addr = AW'(pos_ff);
      end

      res_data.band_index = BAND_W'(best_idx_ff);
      res_data.distance   = best_ff;
      res_data.matched    = (32'(product) < MATCH_LIMIT);

      unique case (state_ff)
         ST_IDLE: begin
            if (!op_empty) begin
               op_pop   = 1'b1;
               rgb_in   = op_rgb;
               count_in = op_count;
               if (op_kind == OP_WRITE) begin
                  wr_en = 1'b1;
               end else begin
                  state_in = ST_CLAMP;
               end
            end
         end
         ST_CLAMP: begin
            // Clamp both window ends to the stored count and the band count to range.
            lo_in = (XW'(lower_bound) > cnt_x) ? count_ff : CW'(lower_bound);
            hi_in = (XW'(upper_bound) > cnt_x) ? count_ff : CW'(upper_bound);
            if (legend_count < LEGEND_W'(LEGEND_MIN)) begin
               bands_in = BW'(1);
            end else if (32'(legend_count) > MAX_LEGEND) begin
               bands_in = BW'(MAX_LEGEND - 1);
            end else begin
               bands_in = BW'(legend_count - LEGEND_W'(1));
            end
            state_in = ST_ORDER;
         end
         ST_ORDER: begin
            // Order the ends and load the window width as the dividend.
            if (lo_ff > hi_ff) begin
               lo_in   = hi_ff;
               quot_in = lo_ff - hi_ff;
            end else begin
               quot_in = hi_ff - lo_ff;
            end
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            // Restoring division, one quotient bit per cycle.
            if (rem_shift >= {1'b0, bands_ff}) begin
               rem_in  = rem_diff[BW-1:0];
               quot_in = {quot_ff[CW-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift[BW-1:0];
               quot_in = {quot_ff[CW-2:0], 1'b0};
            end
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(CW - 1)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            chunk_in    = quot_ff;
            pos_in      = lo_ff + (quot_ff >> 1);
            issue_in    = '0;
            best_in     = NO_MATCH_DIST;
            best_idx_in = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            // One band center read per cycle via read data and distance registers.
            if (issue_more) begin
               rd_valid_in = 1'b1;
               issue_in    = issue_ff + BW'(1);
               pos_in      = pos_ff + chunk_ff;
            end
            if (dist_valid_ff && (dist_ff < SUM_W'(best_ff))) begin
               best_in     = DIST_W'(dist_ff);
               best_idx_in = dist_idx_ff;
            end
            if (!issue_more && !rd_valid_ff && !dist_valid_ff) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!res_full) begin
               res_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         issue_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         dist_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         issue_ff      <= issue_in;
         rd_valid_ff   <= rd_valid_in;
         dist_valid_ff <= dist_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rgb_ff      <= rgb_in;
      count_ff    <= count_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      bands_ff    <= bands_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      chunk_ff    <= chunk_in;
      pos_ff      <= pos_in;
      rd_idx_ff   <= rd_idx_in;
      dist_ff     <= dist_in;
      dist_idx_ff <= dist_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
   end

   // Store memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[AW'(op_count)] <= op_rgb;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

endmodule

// ----- design/legend_color_band_matcher.sv -----
// Top level of the legend color band matcher: ports, configuration registers and queues.
//
// The block captures a palette of pixel colors into an internal store and then maps each
// later pixel to the legend band whose center color is nearest by L1 RGB distance. Input
// transactions enter a four-entry operation queue after the front end classifies them;
// begin-capture, end-capture and unused commands finish at acceptance, and a captured
// sample is written into the store by the back end from its idle state. A match steps the
// back end through the clamp, order, divide, prepare, scan and result states: the window
// width, held in the store count width (11 bits at the default depth of 1024), is divided
// by the band count in a one-bit-per-cycle divider, then one band center is read from the
// store memory per cycle through a short distance pipeline. Results wait in a two-entry
// output queue, and configuration must be written only while no transaction is in flight;
// the block itself does not enforce it.
module legend_color_band_matcher
   import lcbm_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT,
   parameter int MAX_LEGEND  = MAX_LEGEND_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input queue side.
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [1:0]             req_command,
   input  logic [CHANNEL_W-1:0]   req_red,
   input  logic [CHANNEL_W-1:0]   req_green,
   input  logic [CHANNEL_W-1:0]   req_blue,
   // Result queue side.
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [BAND_W-1:0]      rsp_band_index,
   output logic                   rsp_matched,
   output logic [DIST_W-1:0]      rsp_distance,
   // Configuration write port.
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW  = $clog2(STORE_DEPTH + 1);
   localparam int OPW = 1 + CW + COLOR_W;

   logic [BOUND_W-1:0]  lower_ff;
   logic [BOUND_W-1:0]  upper_ff;
   logic [LEGEND_W-1:0] legend_ff;

   logic           op_push;
   logic [OPW-1:0] op_wdata;
   logic           op_full;
   logic           op_pop;
   logic [OPW-1:0] op_rdata;
   logic           op_empty;

   logic       res_push;
   logic       res_full;
   result_type res_wdata;
   result_type res_rdata;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff  <= '0;
         upper_ff  <= '0;
         legend_ff <= LEGEND_W'(LEGEND_MIN);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LOWER:  lower_ff  <= csr_wdata[BOUND_W-1:0];
            CSR_UPPER:  upper_ff  <= csr_wdata[BOUND_W-1:0];
            CSR_LEGEND: legend_ff <= csr_wdata[LEGEND_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_full = op_full;

   lcbm_front #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_command (req_command),
      .req_red     (req_red),
      .req_green   (req_green),
      .req_blue    (req_blue),
      .op_full     (op_full),
      .op_push     (op_push),
      .op_data     (op_wdata)
   );

   lcbm_fifo #(
      .WIDTH (OPW),
      .DEPTH (OP_QUEUE_DEPTH)
   ) u_op_queue (
      .clock (clock),
      .reset (reset),
      .push  (op_push),
      .wdata (op_wdata),
      .full  (op_full),
      .pop   (op_pop),
      .rdata (op_rdata),
      .empty (op_empty)
   );

   lcbm_back #(
      .STORE_DEPTH (STORE_DEPTH),
      .MAX_LEGEND  (MAX_LEGEND)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .op_empty     (op_empty),
      .op_data      (op_rdata),
      .op_pop       (op_pop),
      .lower_bound  (lower_ff),
      .upper_bound  (upper_ff),
      .legend_count (legend_ff),
      .res_full     (res_full),
      .res_push     (res_push),
      .res_data     (res_wdata)
   );

   lcbm_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res_wdata),
      .full  (res_full),
      .pop   (rsp_pop),
      .rdata (res_rdata),
      .empty (rsp_empty)
   );

   // Result transaction fields.
   assign rsp_band_index = res_rdata.band_index;
   assign rsp_matched    = res_rdata.matched;
   assign rsp_distance   = res_rdata.distance;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the legend color band matcher, with its own band prediction.
`timescale 1ns / 1ps

module tb_top;
   import lcbm_pkg::*;

   localparam int ITEM_TARGET  = 1550;
   localparam int DRAIN_CYCLES = 64;
   localparam int REPORT_LIMIT = 10;
   localparam int DEPTH        = STORE_DEPTH_DEFAULT;
   localparam int PAL_AW       = $clog2(DEPTH);
   localparam int LEGEND_MAX   = MAX_LEGEND_DEFAULT;
   localparam int BOUND_MAX    = (1 << BOUND_W) - 1;
   localparam int LEGEND_TOP   = (1 << LEGEND_W) - 1;
   // The fourth command code has no meaning; the block must ignore it.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Clock, reset and block ports; the ones driven here are known from time zero.
   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_push         = 1'b0;
   logic                   req_full;
   logic [1:0]             req_command      = CMD_END;
   logic [CHANNEL_W-1:0]   req_red          = '0;
   logic [CHANNEL_W-1:0]   req_green        = '0;
   logic [CHANNEL_W-1:0]   req_blue         = '0;
   logic                   rsp_empty;
   logic                   rsp_pop          = 1'b0;
   logic [BAND_W-1:0]      rsp_band_index;
   logic                   rsp_matched;
   logic [DIST_W-1:0]      rsp_distance;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = CSR_LOWER;
   logic [CSR_DATA_W-1:0]  csr_wdata        = '0;

   // Predicted state of the block and its registers.
   logic [COLOR_W-1:0] palette_mem [DEPTH];
   int                 palette_count  = 0;
   bit                 capture_on     = 1'b0;
   int                 win_lower      = 0;
   int                 win_upper      = 0;
   int                 legend_setting = LEGEND_MIN;

   // Band matches still to come out of the block, oldest first.
   result_type         awaited_matches [$];
   int                 error_count = 0;
   int                 items_sent  = 0;
   bit                 send_gaps   = 1'b1;
   bit                 pop_stalls  = 1'b1;

   legend_color_band_matcher dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_command      (req_command),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_band_index   (rsp_band_index),
      .rsp_matched      (rsp_matched),
      .rsp_distance     (rsp_distance),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 50 MHz clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int chan_gap(input logic [CHANNEL_W-1:0] a, input logic [CHANNEL_W-1:0] b);
      return (a > b) ? int'(a - b) : int'(b - a);
   endfunction

   function automatic logic [CHANNEL_W-1:0] rand_channel();
      return CHANNEL_W'($urandom_range(255));
   endfunction

   // Update the predicted state with one accepted transaction and work out its band match.
   function automatic void apply_item(input logic [1:0] cmd, input logic [CHANNEL_W-1:0] r,
                                      input logic [CHANNEL_W-1:0] g,
                                      input logic [CHANNEL_W-1:0] b,
                                      output bit produced, output result_type res);
      int lo, hi, swap_v, n_leg, bands, chunk, n, pos, gap_sum, best, best_band;
      logic [COLOR_W-1:0] c;
      produced = 1'b0;
      res = '0;
      case (cmd)
         CMD_BEGIN: begin
            palette_count = 0;
            capture_on = 1'b1;
         end
         CMD_END: capture_on = 1'b0;
         CMD_SAMPLE: begin
            if (capture_on) begin
               // A full store drops the sample.
               if (palette_count < DEPTH) begin
                  palette_mem[PAL_AW'(palette_count)] = {r, g, b};
                  palette_count++;
               end
            end else if (palette_count != 0) begin
               // Clamp both ends to the store, then put them in order.
               lo = (win_lower > palette_count) ? palette_count : win_lower;
               hi = (win_upper > palette_count) ? palette_count : win_upper;
               if (lo > hi) begin
                  swap_v = lo;
                  lo = hi;
                  hi = swap_v;
               end
               n_leg = legend_setting;
               if (n_leg < LEGEND_MIN) n_leg = LEGEND_MIN;
               if (n_leg > LEGEND_MAX) n_leg = LEGEND_MAX;
               bands = n_leg - 1;
               chunk = (hi - lo) / bands;
               best = int'(NO_MATCH_DIST);
               best_band = 0;
               // The first band center with a strictly smaller distance wins.
               for (n = 0; n < bands; n++) begin
                  pos = lo + n * chunk + chunk / 2;
                  if (pos >= palette_count) pos = palette_count - 1;
                  c = palette_mem[PAL_AW'(pos)];
                  gap_sum = chan_gap(r, c[23:16]) + chan_gap(g, c[15:8])
                            + chan_gap(b, c[7:0]);
                  if (gap_sum < best) begin
                     best = gap_sum;
                     best_band = n;
                  end
               end
               produced = 1'b1;
               res.band_index = best_band[BAND_W-1:0];
               res.matched = (best * bands < MATCH_LIMIT);
               res.distance = best[DIST_W-1:0];
            end
         end
         default: ;
      endcase
   endfunction

   // Send one transaction, with random idle cycles ahead of it. The push stays high on
   // return, so every caller either sends again or lowers it in the same time step.
   task automatic send_item(input logic [1:0] cmd, input logic [CHANNEL_W-1:0] r,
                            input logic [CHANNEL_W-1:0] g, input logic [CHANNEL_W-1:0] b);
      bit produced;
      result_type res;
      while (send_gaps && $urandom_range(99) < 19) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_command <= cmd;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      do @(posedge clock); while (req_full);
      apply_item(cmd, r, g, b, produced, res);
      if (produced) awaited_matches.push_back(res);
      if (cmd != CMD_UNUSED) items_sent++;
   endtask

   // Stop sending, let every match come out, then give queued writes time to finish.
   task automatic wait_idle();
      req_push <= 1'b0;
      while (awaited_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all three registers back to back; only called while the block is idle.
   task automatic write_config(input int lower, input int upper, input int legend);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_LOWER;
      csr_wdata <= lower[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index <= CSR_UPPER;
      csr_wdata <= upper[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index <= CSR_LEGEND;
      csr_wdata <= CSR_DATA_W'(legend[LEGEND_W-1:0]);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      win_lower = lower & BOUND_MAX;
      win_upper = upper & BOUND_MAX;
      legend_setting = legend & LEGEND_TOP;
   endtask

   function automatic logic [CHANNEL_W-1:0] nudge(input logic [CHANNEL_W-1:0] c);
      int v;
      v = int'(c) + int'($urandom_range(20)) - 10;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[CHANNEL_W-1:0];
   endfunction

   // Mostly bounds near the stored count, so clamping and narrow windows both show up.
   function automatic int pick_bound();
      int roll;
      roll = $urandom_range(99);
      if (roll < 65) return $urandom_range(palette_count + 8);
      if (roll < 85) return $urandom_range(BOUND_MAX);
      case ($urandom_range(3))
         0: return 0;
         1: return DEPTH - 1;
         2: return DEPTH;
         default: return BOUND_MAX;
      endcase
   endfunction

   function automatic int pick_legend();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) return $urandom_range(LEGEND_MAX, LEGEND_MIN);
      if (roll < 80) return $urandom_range(LEGEND_TOP);
      case ($urandom_range(5))
         0: return 0;
         1: return 1;
         2: return LEGEND_MIN;
         3: return LEGEND_MAX;
         4: return LEGEND_MAX + 1;
         default: return LEGEND_TOP;
      endcase
   endfunction

   // A pixel close to a stored color half of the time, any pixel otherwise.
   task automatic send_match();
      logic [COLOR_W-1:0] c;
      if (palette_count != 0 && $urandom_range(1) == 1) begin
         c = palette_mem[PAL_AW'($urandom_range(palette_count - 1))];
         send_item(CMD_SAMPLE, nudge(c[23:16]), nudge(c[15:8]), nudge(c[7:0]));
      end else begin
         send_item(CMD_SAMPLE, rand_channel(), rand_channel(), rand_channel());
      end
   endtask

   // A burst of pixels with an occasional stray end or unused command among them.
   task automatic send_matches(input int count);
      repeat (count) begin
         if ($urandom_range(9) == 0)
            send_item(($urandom_range(1) == 1) ? CMD_UNUSED : CMD_END,
                      rand_channel(), rand_channel(), rand_channel());
         else
            send_match();
      end
   endtask

   // Empty store, ignored commands, default registers, swapped and clamped bounds,
   // out-of-range legend counts, zero-width bands and centers past the stored count.
   task automatic test_directed_cases();
      send_item(CMD_SAMPLE, 8'd0, 8'd0, 8'd0);
      send_item(CMD_UNUSED, 8'd255, 8'd255, 8'd255);
      send_item(CMD_END, 8'd0, 8'd0, 8'd0);
      send_item(CMD_BEGIN, 8'd0, 8'd0, 8'd0);
      send_item(CMD_SAMPLE, 8'd0, 8'd0, 8'd0);
      send_item(CMD_SAMPLE, 8'd255, 8'd255, 8'd255);
      send_item(CMD_SAMPLE, 8'd255, 8'd0, 8'd0);
      send_item(CMD_SAMPLE, 8'd0, 8'd255, 8'd0);
      send_item(CMD_SAMPLE, 8'd0, 8'd0, 8'd255);
      send_item(CMD_SAMPLE, 8'd128, 8'd128, 8'd128);
      send_item(CMD_UNUSED, 8'd1, 8'd2, 8'd3);
      send_item(CMD_END, 8'd255, 8'd255, 8'd255);
      // Registers at their reset values: one band centered on the first entry.
      send_item(CMD_SAMPLE, 8'd0, 8'd0, 8'd0);
      send_item(CMD_SAMPLE, 8'd255, 8'd255, 8'd255);
      wait_idle();
      write_config(0, 6, 7);
      send_item(CMD_SAMPLE, 8'd255, 8'd0, 8'd0);
      send_item(CMD_SAMPLE, 8'd1, 8'd254, 8'd3);
      // Swapped bounds with the lower one past the store, legend count below the minimum.
      wait_idle();
      write_config(BOUND_MAX, 0, 0);
      send_item(CMD_SAMPLE, 8'd0, 8'd250, 8'd0);
      // Empty window at the stored count with legend count above the maximum.
      wait_idle();
      write_config(DEPTH, DEPTH, LEGEND_TOP);
      send_item(CMD_SAMPLE, 8'd0, 8'd0, 8'd0);
      send_item(CMD_SAMPLE, 8'd128, 8'd128, 8'd128);
   endtask

   // Overfill the store so later samples are dropped, then match across the whole of it.
   task automatic test_store_overflow();
      send_item(CMD_BEGIN, rand_channel(), rand_channel(), rand_channel());
      repeat (DEPTH + 6)
         send_item(CMD_SAMPLE, rand_channel(), rand_channel(), rand_channel());
      send_item(CMD_END, rand_channel(), rand_channel(), rand_channel());
      wait_idle();
      write_config(0, DEPTH, LEGEND_MAX);
      send_matches(8);
      wait_idle();
      write_config(BOUND_MAX, DEPTH - 4, 5);
      send_matches(4);
   endtask

   // Random palettes and register settings; mostly well-formed captures, some noise.
   task automatic test_random_palettes();
      int phase, n_samples;
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         // A stretch of phases runs with no idling on either side.
         send_gaps = !(phase >= 3 && phase < 9);
         pop_stalls = send_gaps;
         if ($urandom_range(99) < 80) begin
            n_samples = ($urandom_range(9) == 0) ? $urandom_range(300, 41)
                                                 : $urandom_range(40, 1);
            send_item(CMD_BEGIN, rand_channel(), rand_channel(), rand_channel());
            repeat (n_samples)
               send_item(CMD_SAMPLE, rand_channel(), rand_channel(), rand_channel());
            send_item(CMD_END, rand_channel(), rand_channel(), rand_channel());
         end else begin
            repeat ($urandom_range(8, 1))
               send_item(2'($urandom_range(3)), rand_channel(), rand_channel(),
                         rand_channel());
         end
         // Two register settings against the same palette.
         repeat (2) begin
            wait_idle();
            write_config(pick_bound(), pick_bound(), pick_legend());
            send_matches($urandom_range(16, 4));
         end
         phase++;
      end
   endtask

   // Accept results with random stalls and compare each with the oldest predicted match.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (!rsp_empty && rsp_pop) begin
            if (awaited_matches.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("unexpected result: band %0d matched %0b distance %0d",
                           rsp_band_index, rsp_matched, rsp_distance);
            end else begin
               want = awaited_matches.pop_front();
               if (rsp_band_index !== want.band_index || rsp_matched !== want.matched ||
                   rsp_distance !== want.distance) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display("mismatch: expected band %0d matched %0b distance %0d",
                              want.band_index, want.matched, want.distance,
                              ", got band %0d matched %0b distance %0d",
                              rsp_band_index, rsp_matched, rsp_distance);
               end
            end
         end
         rsp_pop <= !(pop_stalls && $urandom_range(99) < 19);
      end
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #10ms;
      $display("FAILURE");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_store_overflow();
      test_random_palettes();
      wait_idle();
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
